// ===== rtl/core/siat_pkg.sv =====
// Package for the sorted interval allocation table.
// Field widths, result codes and the per-entry compare flags.
// No dependencies.
package siat_pkg;

    localparam int START_W     = 48;
    localparam int LEN_W       = 32;
    localparam int POS_W       = 6;
    localparam int USED_W      = 7;
    localparam int S_TDATA_W   = 80;
    localparam int M_TDATA_W   = 16;
    localparam int M_TUSER_W   = 2;

    typedef enum logic [1:0] {
        ST_ALLOCATED = 2'd0,
        ST_OVERLAP   = 2'd1,
        ST_INSERTED  = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic hit;
        logic ovl;
        logic below;
    } cmp_t;

endpackage

// ===== rtl/core/sorted_interval_alloc_table.sv =====
// Sorted interval allocation table: top level, entry memory and sequencer.
// A match, conflict or full result follows a scan of all n stored ranges; an insert at
// p < n first shifts entries p..n-1 up by one, an append (p = n) writes directly, and an
// empty table skips the scan. s_tready is high only in idle, so requests are not overlapped.
// Reset clears the range count, state and valid flags; no clearing pass, the memory is not touched.
// Depends on siat_pkg and siat_entry_cmp.
module sorted_interval_alloc_table import siat_pkg::*; #(
    parameter int TABLE_ENTRIES = 64,
    parameter int ADDRESS_BITS  = 48
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // request_start[47:0], request_length[79:48]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // entry_position[5:0], entries_used[12:6], zeros
    output logic [M_TUSER_W-1:0] m_tuser    // status[1:0]
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int ENT_W = ADDRESS_BITS + LEN_W;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_DECIDE = 6'b000100,
        S_SHIFT  = 6'b001000,
        S_WRITE  = 6'b010000,
        S_FIN    = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [ADDRESS_BITS-1:0] req_start_reg, req_start_next;
    logic [LEN_W-1:0]        req_len_reg, req_len_next;
    logic [CNT_W-1:0]        n_reg, n_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic                    issue_reg, issue_next;
    logic                    pend_reg, pend_next;
    logic [IDX_W-1:0]        pend_idx_reg, pend_idx_next;
    logic                    hit_reg, hit_next;
    logic [IDX_W-1:0]        hit_pos_reg, hit_pos_next;
    logic                    ovl_reg, ovl_next;
    logic [IDX_W-1:0]        ovl_pos_reg, ovl_pos_next;
    logic [CNT_W-1:0]        below_reg, below_next;
    status_t                 res_status_reg, res_status_next;
    logic [IDX_W-1:0]        res_pos_reg, res_pos_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]    m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0]    m_tuser_reg, m_tuser_next;

    logic [ENT_W-1:0] mem [TABLE_ENTRIES];
    logic [ENT_W-1:0] rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [ENT_W-1:0] wr_data;
    logic [IDX_W-1:0] last_idx;
    cmp_t             cmp;

    siat_entry_cmp #(
        .ADDRESS_BITS(ADDRESS_BITS)
    ) u_cmp (
        .entry_start (rd_data_reg[ADDRESS_BITS-1:0]),
        .entry_len   (rd_data_reg[ENT_W-1:ADDRESS_BITS]),
        .req_start   (req_start_reg),
        .req_len     (req_len_reg),
        .cmp         (cmp)
    );

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        state_next      = state_reg;
        req_start_next  = req_start_reg;
        req_len_next    = req_len_reg;
        n_next          = n_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        issue_next      = issue_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        hit_next        = hit_reg;
        hit_pos_next    = hit_pos_reg;
        ovl_next        = ovl_reg;
        ovl_pos_next    = ovl_pos_reg;
        below_next      = below_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        rd_addr         = idx_reg;
        wr_en           = 1'b0;
        wr_addr         = IDX_W'(pend_idx_reg + 1'b1);
        wr_data         = rd_data_reg;
        last_idx        = IDX_W'(n_reg - 1'b1);

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    req_start_next = ADDRESS_BITS'(s_tdata[START_W-1:0]);
                    req_len_next   = s_tdata[START_W+LEN_W-1:START_W];
                    n_next         = count_reg;
                    hit_next       = 1'b0;
                    ovl_next       = 1'b0;
                    below_next     = '0;
                    idx_next       = '0;
                    issue_next     = 1'b1;
                    pend_next      = 1'b0;
                    state_next     = (count_reg == '0) ? S_DECIDE : S_SCAN;
                end
            end
            S_SCAN: begin
                pend_next = issue_reg;
                if (issue_reg) begin
                    pend_idx_next = idx_reg;
                    idx_next      = IDX_W'(idx_reg + 1'b1);
                    if (idx_reg == last_idx) begin
                        issue_next = 1'b0;
                    end
                end
                if (pend_reg) begin
                    if (cmp.hit && !hit_reg) begin
                        hit_next     = 1'b1;
                        hit_pos_next = pend_idx_reg;
                    end
                    if (cmp.ovl && !ovl_reg) begin
                        ovl_next     = 1'b1;
                        ovl_pos_next = pend_idx_reg;
                    end
                    if (cmp.below) begin
                        below_next = CNT_W'(below_reg + 1'b1);
                    end
                    if (pend_idx_reg == last_idx) begin
                        pend_next  = 1'b0;
                        state_next = S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                if (hit_reg) begin
                    res_status_next = ST_ALLOCATED;
                    res_pos_next    = hit_pos_reg;
                    state_next      = S_FIN;
                end else if (ovl_reg) begin
                    res_status_next = ST_OVERLAP;
                    res_pos_next    = ovl_pos_reg;
                    state_next      = S_FIN;
                end else if (n_reg == CNT_W'(TABLE_ENTRIES)) begin
                    res_status_next = ST_FULL;
                    res_pos_next    = '0;
                    state_next      = S_FIN;
                end else begin
                    res_status_next = ST_INSERTED;
                    res_pos_next    = below_reg[IDX_W-1:0];
                    if (below_reg == n_reg) begin
                        state_next = S_WRITE;
                    end else begin
                        idx_next   = last_idx;
                        issue_next = 1'b1;
                        pend_next  = 1'b0;
                        state_next = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                // read entry i, write it to i+1 in the following cycle, walking downwards
                pend_next = issue_reg;
                if (issue_reg) begin
                    pend_idx_next = idx_reg;
                    idx_next      = IDX_W'(idx_reg - 1'b1);
                    if (idx_reg == res_pos_reg) begin
                        issue_next = 1'b0;
                    end
                end
                if (pend_reg) begin
                    wr_en = 1'b1;
                    if (pend_idx_reg == res_pos_reg) begin
                        pend_next  = 1'b0;
                        state_next = S_WRITE;
                    end
                end
            end
            S_WRITE: begin
                wr_en      = 1'b1;
                wr_addr    = res_pos_reg;
                wr_data    = {req_len_reg, req_start_reg};
                count_next = CNT_W'(count_reg + 1'b1);
                state_next = S_FIN;
            end
            S_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = M_TUSER_W'(res_status_reg);
                    m_tdata_next  = M_TDATA_W'({USED_W'(count_reg), POS_W'(res_pos_reg)});
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            issue_reg    <= 1'b0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            issue_reg    <= issue_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_start_reg  <= req_start_next;
        req_len_reg    <= req_len_next;
        n_reg          <= n_next;
        idx_reg        <= idx_next;
        pend_idx_reg   <= pend_idx_next;
        hit_reg        <= hit_next;
        hit_pos_reg    <= hit_pos_next;
        ovl_reg        <= ovl_next;
        ovl_pos_reg    <= ovl_pos_next;
        below_reg      <= below_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

endmodule

// ===== rtl/core/siat_entry_cmp.sv =====
// Compares one stored range against the request: exact start, overlap, below.
// Ranges are half-open; overlap is tested on the start difference.
// Depends on siat_pkg.
module siat_entry_cmp import siat_pkg::*; #(
    parameter int ADDRESS_BITS = 48
) (
    input  logic [ADDRESS_BITS-1:0] entry_start,
    input  logic [LEN_W-1:0]        entry_len,
    input  logic [ADDRESS_BITS-1:0] req_start,
    input  logic [LEN_W-1:0]        req_len,
    output cmp_t                    cmp
);

    logic                    entry_first;
    logic [ADDRESS_BITS-1:0] diff;
    logic [ADDRESS_BITS-1:0] span;

    always_comb begin
        entry_first = (entry_start <= req_start);
        if (entry_first) begin
            diff = req_start - entry_start;
            span = ADDRESS_BITS'(entry_len);
        end else begin
            diff = entry_start - req_start;
            span = ADDRESS_BITS'(req_len);
        end
        cmp.hit   = (entry_start == req_start);
        cmp.below = (entry_start < req_start);
        cmp.ovl   = !cmp.hit && (diff < span);
    end

endmodule
